[hdl/cpfl_pkg.sv]
// shared types, constants and helper functions for the class-partitioned free list
`timescale 1ns / 1ps
`default_nettype none

package cpfl_pkg;

	localparam int TEMP_COUNT = 7;
	localparam int SAVE_COUNT = 12;
	localparam int ARG_COUNT  = 8;
	localparam int POOL_SIZE  = TEMP_COUNT + SAVE_COUNT + ARG_COUNT;
	localparam int IDX_W      = 5;

	typedef logic [POOL_SIZE-1:0] pool_t;

	typedef enum logic [2:0] {
		OP_ALLOC   = 3'd0,
		OP_CLAIM   = 3'd1,
		OP_RELEASE = 3'd2,
		OP_CLEAR   = 3'd3,
		OP_QUERY   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		CLS_TEMP = 2'd0,
		CLS_SAVE = 2'd1,
		CLS_ARG  = 2'd2
	} class_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NONE_FREE = 2'd1,
		ST_INVALID   = 2'd2,
		ST_IN_USE    = 2'd3
	} status_t;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] granted_index;
		logic             in_use;
		logic [1:0]       index_class;
		logic             class_has_free;
		pool_t            used_mask;
	} result_t;

	// registers that belong to a class; an unused class code is empty
	function automatic pool_t class_mask(logic [1:0] cls);
		pool_t m;
		m = '0;
		for (int i = 0; i < POOL_SIZE; i++) begin
			if (cls == CLS_TEMP && i < TEMP_COUNT) begin
				m[i] = 1'b1;
			end
			if (cls == CLS_SAVE && i >= TEMP_COUNT && i < TEMP_COUNT + SAVE_COUNT) begin
				m[i] = 1'b1;
			end
			if (cls == CLS_ARG && i >= TEMP_COUNT + SAVE_COUNT) begin
				m[i] = 1'b1;
			end
		end
		return m;
	endfunction

	function automatic logic [1:0] class_of(logic [IDX_W-1:0] idx);
		logic [1:0] c;
		if (idx < IDX_W'(TEMP_COUNT)) begin
			c = CLS_TEMP;
		end else if (idx < IDX_W'(TEMP_COUNT + SAVE_COUNT)) begin
			c = CLS_SAVE;
		end else begin
			c = CLS_ARG;
		end
		return c;
	endfunction

	// priority encoder, lowest set bit wins
	function automatic logic [IDX_W-1:0] lowest_one(pool_t v);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = POOL_SIZE - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[hdl/cpfl_core.sv]
// operation logic: decodes one item against the used bits and forms the result
`timescale 1ns / 1ps
`default_nettype none

module cpfl_core (
	input  wire logic [2:0]                 op,
	input  wire logic [1:0]                 reg_class,
	input  wire logic [cpfl_pkg::IDX_W-1:0] reg_index,
	input  wire cpfl_pkg::pool_t            used,
	output cpfl_pkg::pool_t                 used_next,
	output cpfl_pkg::result_t               res
);

	logic                         idx_valid;
	cpfl_pkg::pool_t              idx_bit;
	cpfl_pkg::pool_t              avail;
	logic [cpfl_pkg::IDX_W-1:0]   free_idx;

	assign idx_valid = reg_index < cpfl_pkg::IDX_W'(cpfl_pkg::POOL_SIZE);
	assign idx_bit   = cpfl_pkg::pool_t'(1) << reg_index;
	assign avail     = cpfl_pkg::class_mask(reg_class) & ~used;
	assign free_idx  = cpfl_pkg::lowest_one(avail);

	always_comb begin
		used_next         = used;
		res.status        = cpfl_pkg::ST_OK;
		res.granted_index = '0;
		res.in_use        = 1'b0;
		res.index_class   = '0;
		unique case (cpfl_pkg::op_t'(op))
			cpfl_pkg::OP_ALLOC: begin
				if (avail == '0) begin
					res.status = cpfl_pkg::ST_NONE_FREE;
				end else begin
					used_next         = used | (cpfl_pkg::pool_t'(1) << free_idx);
					res.granted_index = free_idx;
					res.index_class   = reg_class;
				end
			end
			cpfl_pkg::OP_CLAIM: begin
				if (!idx_valid) begin
					res.status = cpfl_pkg::ST_INVALID;
				end else if ((used & idx_bit) != '0) begin
					res.status      = cpfl_pkg::ST_IN_USE;
					res.index_class = cpfl_pkg::class_of(reg_index);
				end else begin
					used_next         = used | idx_bit;
					res.granted_index = reg_index;
					res.index_class   = cpfl_pkg::class_of(reg_index);
				end
			end
			cpfl_pkg::OP_RELEASE: begin
				// releasing a free index is allowed and reports ok
				if (!idx_valid) begin
					res.status = cpfl_pkg::ST_INVALID;
				end else begin
					used_next       = used & ~idx_bit;
					res.index_class = cpfl_pkg::class_of(reg_index);
				end
			end
			cpfl_pkg::OP_CLEAR: begin
				used_next = '0;
			end
			cpfl_pkg::OP_QUERY: begin
				if (!idx_valid) begin
					res.status = cpfl_pkg::ST_INVALID;
				end else begin
					res.in_use      = (used & idx_bit) != '0;
					res.index_class = cpfl_pkg::class_of(reg_index);
				end
			end
			default: begin
				// unused opcodes leave everything alone
			end
		endcase
		res.class_has_free = (cpfl_pkg::class_mask(reg_class) & ~used_next) != '0;
		res.used_mask      = used_next;
	end

endmodule

`default_nettype wire

[hdl/class_partitioned_free_list_unit.sv]
// top level of the class-partitioned register free list
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_ready  | op, reg_class, reg_index
//   out     | output    | out_valid/out_ready| status, granted_index, in_use,
//           |           |                    | index_class, class_has_free, used_mask
//
// one item per cycle sustained while out_ready is high; an item passes through the input
// register, then the result register, and its mask update is registered with it:
// the used bits change at the edge where an item moves into the result register
// reset clears the used bits and both valid flags; no clearing pass
// with out_ready low the result holds, an item is still taken into the input register
// if that register is empty, then in_ready drops until the result is taken
`timescale 1ns / 1ps
`default_nettype none

module class_partitioned_free_list_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [2:0]                   op,
	input  wire logic [1:0]                   reg_class,
	input  wire logic [cpfl_pkg::IDX_W-1:0]   reg_index,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [1:0]                        status,
	output logic [cpfl_pkg::IDX_W-1:0]        granted_index,
	output logic                              in_use,
	output logic [1:0]                        index_class,
	output logic                              class_has_free,
	output logic [cpfl_pkg::POOL_SIZE-1:0]    used_mask
);

	logic                         valid_s1;
	logic [2:0]                   op_s1;
	logic [1:0]                   class_s1;
	logic [cpfl_pkg::IDX_W-1:0]   index_s1;
	cpfl_pkg::pool_t              used_q;
	cpfl_pkg::pool_t              used_next;
	cpfl_pkg::result_t            res;
	cpfl_pkg::result_t            res_q;
	logic                         out_valid_q;
	logic                         advance;

	// stage one moves on when the result register is empty or being emptied
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	cpfl_core u_core (
		.op        (op_s1),
		.reg_class (class_s1),
		.reg_index (index_s1),
		.used      (used_q),
		.used_next (used_next),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			used_q      <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				used_q      <= used_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1    <= op;
			class_s1 <= reg_class;
			index_s1 <= reg_index;
		end
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = res_q.status;
	assign granted_index  = res_q.granted_index;
	assign in_use         = res_q.in_use;
	assign index_class    = res_q.index_class;
	assign class_has_free = res_q.class_has_free;
	assign used_mask      = res_q.used_mask;

endmodule

`default_nettype wire

[hdl/cpfl_checker.sv]
// port-level checks for the free list, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module cpfl_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [1:0]                   status,
	input wire logic [cpfl_pkg::IDX_W-1:0]   granted_index,
	input wire logic                         in_use,
	input wire logic                         class_has_free,
	input wire logic [cpfl_pkg::POOL_SIZE-1:0] used_mask
);

	// a stalled result holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(used_mask)
			&& $stable(granted_index))
		else $error("result changed while stalled");

	// a nonzero granted index with ok status is marked used in the mask
	a_grant_marked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == cpfl_pkg::ST_OK && granted_index != '0
			|-> used_mask[granted_index])
		else $error("granted index not set in used mask");

	// an exhausted class grants nothing and reports no free register
	a_none_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == cpfl_pkg::ST_NONE_FREE
			|-> !class_has_free && granted_index == '0 && !in_use)
		else $error("none-free result inconsistent");

	// a used query bit only comes with ok status and a nonempty mask
	a_in_use_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_use |-> status == cpfl_pkg::ST_OK && used_mask != '0)
		else $error("in_use reported on failed item or empty mask");

endmodule

bind class_partitioned_free_list_unit cpfl_checker u_cpfl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.status         (status),
	.granted_index  (granted_index),
	.in_use         (in_use),
	.class_has_free (class_has_free),
	.used_mask      (used_mask)
);

`default_nettype wire

[tb/free_list_checker.sv]
// scoreboard for the class-partitioned free list: predicts each result and compares it
`timescale 1ns / 1ps

module free_list_checker
	import cpfl_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_ready,
	input  wire logic [2:0]           op,
	input  wire logic [1:0]           reg_class,
	input  wire logic [IDX_W-1:0]     reg_index,
	input  wire logic                 out_valid,
	input  wire logic                 out_ready,
	input  wire logic [1:0]           status,
	input  wire logic [IDX_W-1:0]     granted_index,
	input  wire logic                 in_use,
	input  wire logic [1:0]           index_class,
	input  wire logic                 class_has_free,
	input  wire logic [POOL_SIZE-1:0] used_mask,
	output int                        fail_count,
	output int                        outstanding
);

	pool_t   used_regs;
	result_t expected_results[$];

	// index range owned by each class; any other class code owns nothing
	function automatic pool_t class_members(logic [1:0] cls);
		pool_t ones;
		ones = '1;
		case (cls)
			CLS_TEMP: return ones >> (POOL_SIZE - TEMP_COUNT);
			CLS_SAVE: return (ones >> (POOL_SIZE - SAVE_COUNT)) << TEMP_COUNT;
			CLS_ARG:  return ones << (TEMP_COUNT + SAVE_COUNT);
			default:  return '0;
		endcase
	endfunction

	function automatic logic [1:0] class_of_index(logic [IDX_W-1:0] idx);
		if (int'(idx) < TEMP_COUNT) begin
			return CLS_TEMP;
		end
		if (int'(idx) < TEMP_COUNT + SAVE_COUNT) begin
			return CLS_SAVE;
		end
		return CLS_ARG;
	endfunction

	// applies one item to used_regs and returns the result it should produce
	function automatic result_t free_list_step(logic [2:0] o, logic [1:0] cls,
			logic [IDX_W-1:0] idx);
		result_t r;
		pool_t   avail;
		bit      idx_ok;
		bit      found;
		idx_ok = int'(idx) < POOL_SIZE;
		r = '0;
		r.status = ST_OK;
		case (o)
			OP_ALLOC: begin
				avail = class_members(cls) & ~used_regs;
				found = 1'b0;
				for (int i = 0; i < POOL_SIZE; i++) begin
					if (!found && avail[i]) begin
						found = 1'b1;
						used_regs[i] = 1'b1;
						r.granted_index = IDX_W'(i);
						r.index_class = cls;
					end
				end
				if (!found) begin
					r.status = ST_NONE_FREE;
				end
			end
			OP_CLAIM: begin
				if (!idx_ok) begin
					r.status = ST_INVALID;
				end else if (used_regs[idx]) begin
					r.status = ST_IN_USE;
					r.index_class = class_of_index(idx);
				end else begin
					used_regs[idx] = 1'b1;
					r.granted_index = idx;
					r.index_class = class_of_index(idx);
				end
			end
			OP_RELEASE: begin
				// releasing a free register is legal and leaves it free
				if (!idx_ok) begin
					r.status = ST_INVALID;
				end else begin
					used_regs[idx] = 1'b0;
					r.index_class = class_of_index(idx);
				end
			end
			OP_CLEAR: begin
				used_regs = '0;
			end
			OP_QUERY: begin
				if (!idx_ok) begin
					r.status = ST_INVALID;
				end else begin
					r.in_use = used_regs[idx];
					r.index_class = class_of_index(idx);
				end
			end
			default: begin
			end
		endcase
		r.class_has_free = |(class_members(cls) & ~used_regs);
		r.used_mask = used_regs;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t predicted;
		bit      pushed;
		bit      popped;
		if (!arst_n) begin
			used_regs = '0;
			expected_results.delete();
			outstanding <= 0;
		end else begin
			pushed = 1'b0;
			popped = 1'b0;
			// compare before predicting: the block cannot answer an item in the same cycle
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual status %0h mask %0h",
						$time, status, used_mask);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					popped = 1'b1;
					compare_field("status", 32'(want.status), 32'(status));
					compare_field("granted_index", 32'(want.granted_index), 32'(granted_index));
					compare_field("in_use", 32'(want.in_use), 32'(in_use));
					compare_field("index_class", 32'(want.index_class), 32'(index_class));
					compare_field("class_has_free", 32'(want.class_has_free),
						32'(class_has_free));
					compare_field("used_mask", 32'(want.used_mask), 32'(used_mask));
				end
			end
			if (in_valid && in_ready) begin
				predicted = free_list_step(op, reg_class, reg_index);
				expected_results = {expected_results, predicted};
				pushed = 1'b1;
			end
			outstanding <= outstanding + int'(pushed) - int'(popped);
		end
	end

endmodule

[tb/testbench.sv]
// top of the free list testbench: clock, reset, stimulus, flow control and verdict
`timescale 1ns / 1ps

module testbench;
	import cpfl_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEMS_PER_PHASE = 250;
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST = 3'd7;
	localparam logic [1:0] CLS_NONE = 2'd3;
	localparam logic [IDX_W-1:0] IDX_TOP = '1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [2:0]           op = '0;
	logic [1:0]           reg_class = '0;
	logic [IDX_W-1:0]     reg_index = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [1:0]           status;
	logic [IDX_W-1:0]     granted_index;
	logic                 in_use;
	logic [1:0]           index_class;
	logic                 class_has_free;
	logic [POOL_SIZE-1:0] used_mask;

	int fail_count;
	int outstanding;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	class_partitioned_free_list_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.reg_class      (reg_class),
		.reg_index      (reg_index),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.granted_index  (granted_index),
		.in_use         (in_use),
		.index_class    (index_class),
		.class_has_free (class_has_free),
		.used_mask      (used_mask)
	);

	free_list_checker checker_inst (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.reg_class      (reg_class),
		.reg_index      (reg_index),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.granted_index  (granted_index),
		.in_use         (in_use),
		.index_class    (index_class),
		.class_has_free (class_has_free),
		.used_mask      (used_mask),
		.fail_count     (fail_count),
		.outstanding    (outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready = arst_n && ($urandom_range(99) >= stall_pct);
	end

	// called at a falling edge, returns at the falling edge after the item is taken
	task automatic send_item(input logic [2:0] o, input logic [1:0] cls,
			input logic [IDX_W-1:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		op = o;
		reg_class = cls;
		reg_index = idx;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// alloc-heavy mix so classes run full, with some bad indices and spare opcodes
	task automatic send_random_item();
		int          pick;
		logic [2:0]  o;
		logic [1:0]  cls;
		logic [IDX_W-1:0] idx;
		pick = $urandom_range(99);
		if (pick < 35) begin
			o = OP_ALLOC;
		end else if (pick < 50) begin
			o = OP_CLAIM;
		end else if (pick < 70) begin
			o = OP_RELEASE;
		end else if (pick < 73) begin
			o = OP_CLEAR;
		end else if (pick < 93) begin
			o = OP_QUERY;
		end else begin
			o = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
		end
		cls = ($urandom_range(19) == 0) ? CLS_NONE : 2'($urandom_range(CLS_ARG));
		if ($urandom_range(9) == 0) begin
			idx = IDX_W'($urandom_range(IDX_TOP, POOL_SIZE));
		end else begin
			idx = IDX_W'($urandom_range(POOL_SIZE - 1));
		end
		send_item(o, cls, idx);
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item(OP_QUERY, CLS_TEMP, '0);
		send_item(OP_ALLOC, CLS_TEMP, '0);
		send_item(OP_ALLOC, CLS_NONE, '0);
		send_item(OP_CLAIM, CLS_SAVE, IDX_TOP);
		send_item(OP_CLAIM, CLS_SAVE, IDX_W'(POOL_SIZE));
		send_item(OP_CLAIM, CLS_TEMP, '0);
		send_item(OP_RELEASE, CLS_SAVE, IDX_W'(TEMP_COUNT + 6));
		send_item(OP_RELEASE, CLS_ARG, IDX_W'(30));
		send_item(OP_QUERY, CLS_ARG, IDX_W'(29));
		send_item(OP_QUERY, CLS_TEMP, '0);
		for (int s = OP_SPARE_FIRST; s <= OP_SPARE_LAST; s++) begin
			send_item(3'(s), 2'($urandom_range(CLS_NONE)), IDX_W'($urandom_range(IDX_TOP)));
		end
		send_item(OP_CLAIM, CLS_ARG, IDX_W'(POOL_SIZE - 1));
		// the top argument register is taken, so the last alloc finds none free
		for (int k = 0; k < ARG_COUNT; k++) begin
			send_item(OP_ALLOC, CLS_ARG, '0);
		end
		send_item(OP_RELEASE, CLS_ARG, IDX_W'(POOL_SIZE - 1));
		send_item(OP_CLEAR, CLS_SAVE, '0);
		send_item(OP_ALLOC, CLS_SAVE, '0);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 85;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 85;
				end
				default: begin
					send_idle_pct = 8;
					stall_pct = 8;
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_random_item();
			end
		end
		in_valid = 1'b0;

		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[sim.f]
hdl/cpfl_pkg.sv
hdl/cpfl_core.sv
hdl/class_partitioned_free_list_unit.sv
hdl/cpfl_checker.sv
tb/free_list_checker.sv
tb/testbench.sv
